// File: rtl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared constants, types and cell rules for the forest-fire generation step.
// ----------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

  localparam int MAX_WIDTH    = 16;
  localparam int MAX_HEIGHT   = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WCNT_W       = COL_W + 1;
  localparam int HCNT_W       = ROW_W + 1;
  localparam int WIDTH_CFG_W  = 5;
  localparam int HEIGHT_CFG_W = 11;
  localparam int CFG_DATA_W   = 11;
  localparam int CELL_W       = 2;
  localparam int TDATA_W      = 8;

  localparam logic [CELL_W-1:0] CELL_TREE    = 2'd0;
  localparam logic [CELL_W-1:0] CELL_BURNING = 2'd1;
  localparam logic [CELL_W-1:0] CELL_BURNT   = 2'd2;
  localparam logic [CELL_W-1:0] CELL_ODD     = 2'd3;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 5'd10;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 11'd10;

  // column: top cell in the low bits, bottom cell in the high bits
  typedef logic [3*CELL_W-1:0] column_t;
  // window: left column in the low bits
  typedef logic [9*CELL_W-1:0] window_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_state;
    logic [COL_W-1:0]  col;
    logic              row_ge1;
    logic              row_ge2;
    logic              last;
  } cmd_t;

  function automatic logic [WCNT_W-1:0] clamp_width(input logic [WIDTH_CFG_W-1:0] w);
    logic [WCNT_W-1:0] r;
    if (w == '0) begin
      r = WCNT_W'(1);
    end else if (int'(w) > MAX_WIDTH) begin
      r = WCNT_W'(MAX_WIDTH);
    end else begin
      r = WCNT_W'(w);
    end
    return r;
  endfunction

  function automatic logic [HCNT_W-1:0] clamp_height(input logic [HEIGHT_CFG_W-1:0] h);
    logic [HCNT_W-1:0] r;
    if (h == '0) begin
      r = HCNT_W'(1);
    end else if (int'(h) > MAX_HEIGHT) begin
      r = HCNT_W'(MAX_HEIGHT);
    end else begin
      r = HCNT_W'(h);
    end
    return r;
  endfunction

  function automatic window_t shift_col(input window_t win, input column_t c);
    return {c, win[9*CELL_W-1:3*CELL_W]};
  endfunction

  function automatic logic [CELL_W-1:0] cell_next(input window_t win);
    logic [CELL_W-1:0] r;
    logic              hot;
    hot = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (win[CELL_W*k +: CELL_W] == CELL_BURNING) begin
        hot = 1'b1;
      end
    end
    if (win[4*CELL_W +: CELL_W] != CELL_TREE) begin
      r = CELL_BURNT;
    end else if (hot) begin
      r = CELL_BURNING;
    end else begin
      r = CELL_TREE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ffca_front.sv
// ----------------------------------------------------------------------------
// ffca_front
// Accepts cells, tracks the raster position and issues one command per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ffca_pkg::CELL_W-1:0]  cell_state,
  input  wire logic [ffca_pkg::WCNT_W-1:0]  width,
  input  wire logic [ffca_pkg::HCNT_W-1:0]  height,
  output logic                              cmd_valid,
  input  wire logic                         cmd_ready,
  output ffca_pkg::cmd_t                    cmd
);

  logic [ffca_pkg::ROW_W-1:0]  row_position;
  logic [ffca_pkg::COL_W-1:0]  column_position;
  logic [ffca_pkg::ROW_W-1:0]  row_position_next;
  logic [ffca_pkg::COL_W-1:0]  column_position_next;

  logic                        col_wrap;
  logic [ffca_pkg::HCNT_W-1:0] row_a;
  logic [ffca_pkg::COL_W-1:0]  col_a;
  logic [ffca_pkg::ROW_W-1:0]  row_b;
  logic                        is_last;
  logic [ffca_pkg::WCNT_W-1:0] col_inc;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  always_comb begin
    col_wrap = {1'b0, column_position} >= width;
    row_a    = col_wrap ? ({1'b0, row_position} + 1'b1) : {1'b0, row_position};
    col_a    = col_wrap ? '0 : column_position;
    row_b    = (row_a >= height) ? '0 : row_a[ffca_pkg::ROW_W-1:0];
    is_last  = ({1'b0, row_b} == height - 1'b1) && ({1'b0, col_a} == width - 1'b1);
    col_inc  = {1'b0, col_a} + 1'b1;

    if (is_last) begin
      row_position_next    = '0;
      column_position_next = '0;
    end else if (col_inc >= width) begin
      row_position_next    = row_b + 1'b1;
      column_position_next = '0;
    end else begin
      row_position_next    = row_b;
      column_position_next = col_inc[ffca_pkg::COL_W-1:0];
    end

    cmd.cell_state = cell_state;
    cmd.col        = col_a;
    cmd.row_ge1    = row_b != '0;
    cmd.row_ge2    = row_b > ffca_pkg::ROW_W'(1);
    cmd.last       = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position    <= '0;
      column_position <= '0;
    end else if (in_valid && cmd_ready) begin
      row_position    <= row_position_next;
      column_position <= column_position_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ffca_queue.sv
// ----------------------------------------------------------------------------
// ffca_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ffca_pkg::cmd_t in_cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ffca_pkg::cmd_t      out_cmd
);

  ffca_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ffca_back.sv
// ----------------------------------------------------------------------------
// ffca_back
// Line buffers, 3x3 window, end-of-grid drain and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [ffca_pkg::WCNT_W-1:0]  width,
  input  wire logic                         cmd_valid,
  output logic                              cmd_ready,
  input  wire ffca_pkg::cmd_t               cmd,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ffca_pkg::CELL_W-1:0]       new_state,
  output logic                              last_cell
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_TAIL  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  ffca_pkg::window_t           window;
  ffca_pkg::window_t           window_next;
  logic [ffca_pkg::WCNT_W-1:0] drain_col;
  logic [ffca_pkg::WCNT_W-1:0] drain_col_next;
  logic                        tail_ge1;
  logic [ffca_pkg::CELL_W-1:0] upper [ffca_pkg::MAX_WIDTH];
  logic [ffca_pkg::CELL_W-1:0] middle [ffca_pkg::MAX_WIDTH];

  logic                        out_free;
  logic                        step;
  logic [ffca_pkg::COL_W-1:0]  rd_idx;
  logic [ffca_pkg::CELL_W-1:0] up;
  logic [ffca_pkg::CELL_W-1:0] mid;
  ffca_pkg::column_t           column;
  ffca_pkg::window_t           shifted;
  ffca_pkg::window_t           emit_win;
  logic                        emit;
  logic                        emit_last;
  logic                        wr_en;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == ST_RUN) && out_free;
  assign step      = out_free && ((state != ST_RUN) || cmd_valid);

  always_comb begin
    state_next     = state;
    drain_col_next = drain_col;
    rd_idx         = '0;
    up             = '0;
    mid            = '0;
    column         = '0;
    shifted        = '0;
    emit_win       = '0;
    emit           = 1'b0;
    emit_last      = 1'b0;
    wr_en          = 1'b0;
    window_next    = window;

    unique case (state)
      ST_RUN: begin
        rd_idx = cmd.col;
        up     = cmd.row_ge2 ? upper[rd_idx] : '0;
        mid    = cmd.row_ge1 ? middle[rd_idx] : '0;
        column = {cmd.cell_state, mid, up};
        wr_en  = 1'b1;
        if (cmd.col == '0) begin
          emit_win    = ffca_pkg::shift_col(window, '0);
          emit        = cmd.row_ge2;
          window_next = ffca_pkg::shift_col('0, column);
        end else begin
          shifted     = ffca_pkg::shift_col(window, column);
          emit_win    = shifted;
          emit        = cmd.row_ge1;
          window_next = shifted;
        end
        if (cmd.last) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        rd_idx         = '0;
        up             = tail_ge1 ? upper[rd_idx] : '0;
        mid            = middle[rd_idx];
        column         = {ffca_pkg::CELL_TREE, mid, up};
        emit_win       = ffca_pkg::shift_col(window, '0);
        emit           = tail_ge1;
        window_next    = ffca_pkg::shift_col('0, column);
        drain_col_next = ffca_pkg::WCNT_W'(1);
        state_next     = ST_DRAIN;
      end
      ST_DRAIN: begin
        rd_idx = drain_col[ffca_pkg::COL_W-1:0];
        if (drain_col < width) begin
          up     = tail_ge1 ? upper[rd_idx] : '0;
          mid    = middle[rd_idx];
          column = {ffca_pkg::CELL_TREE, mid, up};
        end
        shifted   = ffca_pkg::shift_col(window, column);
        emit_win  = shifted;
        emit      = 1'b1;
        emit_last = drain_col == width;
        if (emit_last) begin
          window_next = '0;
          state_next  = ST_RUN;
        end else begin
          window_next    = shifted;
          drain_col_next = drain_col + 1'b1;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      upper[rd_idx]  <= mid;
      middle[rd_idx] <= cmd.cell_state;
    end
    if (step && emit) begin
      new_state <= ffca_pkg::cell_next(emit_win);
      last_cell <= emit_last;
    end
    if (step && (state == ST_RUN)) begin
      tail_ge1 <= cmd.row_ge1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      window    <= '0;
      drain_col <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        state     <= state_next;
        window    <= window_next;
        drain_col <= drain_col_next;
      end
      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/forest_fire_ca_step.sv
// ----------------------------------------------------------------------------
// forest_fire_ca_step
// One generation of a forest-fire cellular automaton over a raster stream.
//
// Cells enter on the s_ stream in raster order, one cell state per
// transaction; next-generation states leave on the m_ stream in the same
// order, with m_tlast marking the grid's final cell. Grid size is set over
// the cfg_ write channel (index 0 width, index 1 height); the user must do
// so only while the block is idle, as the block itself does not enforce it.
// cfg_ready is always high. Each result is released by the cell one row plus
// one cell later in raster order, or by the end-of-grid drain; m_tvalid rises
// after that transaction has passed the command queue and output register.
// Throughput is one cell per cycle while m_tready is high and no drain runs;
// the grid's final cell holds the window unit in its tail and drain states
// as it flushes the last row; the two-entry queue takes up to two more cells.
// Reset returns the raster position to the grid's top-left corner and the
// size registers to 10 x 10; the line buffers need no clearing.
// When m_tready is low the output register holds its result, the window unit
// stops, and s_tready falls once the command queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module forest_fire_ca_step (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [ffca_pkg::TDATA_W-1:0]      s_tdata,   // [1:0] cell_state
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [ffca_pkg::TDATA_W-1:0]           m_tdata,   // [1:0] new_state
  output logic                                   m_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [ffca_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [ffca_pkg::WIDTH_CFG_W-1:0]  grid_width;
  logic [ffca_pkg::HEIGHT_CFG_W-1:0] grid_height;
  logic [ffca_pkg::WCNT_W-1:0]       width;
  logic [ffca_pkg::HCNT_W-1:0]       height;

  ffca_pkg::cmd_t                    front_cmd;
  logic                              front_valid;
  logic                              front_ready;
  ffca_pkg::cmd_t                    back_cmd;
  logic                              back_valid;
  logic                              back_ready;
  logic [ffca_pkg::CELL_W-1:0]       new_state;

  assign cfg_ready = 1'b1;
  assign width     = ffca_pkg::clamp_width(grid_width);
  assign height    = ffca_pkg::clamp_height(grid_height);
  assign m_tdata   = {{(ffca_pkg::TDATA_W-ffca_pkg::CELL_W){1'b0}}, new_state};

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= ffca_pkg::WIDTH_RESET;
      grid_height <= ffca_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ffca_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data[ffca_pkg::WIDTH_CFG_W-1:0];
        ffca_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  ffca_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .cell_state (s_tdata[ffca_pkg::CELL_W-1:0]),
    .width      (width),
    .height     (height),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready),
    .cmd        (front_cmd)
  );

  ffca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_cmd   (back_cmd)
  );

  ffca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .width     (width),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .new_state (new_state),
    .last_cell (m_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/ffca_checker.sv
// ----------------------------------------------------------------------------
// ffca_checker
// Port-level checks on the forest-fire generation step.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [ffca_pkg::TDATA_W-1:0]    m_tdata,
  input wire logic                            m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_state_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[ffca_pkg::CELL_W-1:0] != ffca_pkg::CELL_ODD)
    else $error("next state out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[ffca_pkg::TDATA_W-1:ffca_pkg::CELL_W] == '0)
    else $error("padding bits set");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered straight after reset");

endmodule

bind forest_fire_ca_step ffca_checker u_ffca_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
